@@ rtl/fba_pkg.sv @@
// fba_pkg: shared types and constants for the frame bitmap allocator.
// Field widths, operation codes and status codes. No dependencies.
package fba_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned FRAME_W  = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_MARK  = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_ALLOC = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_USED  = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

endpackage

@@ rtl/frame_bitmap_allocator.sv @@
// Frame bitmap allocator: used/free bitmap in one synchronous word memory.
// Mark, free and query read the frame's word; an allocate scans words from
// word 0 until it finds a free frame or reaches the last word below the count.
// One transaction in flight at a time; the output register lets a new one start
// while the last result waits. After reset a clearing pass zeroes the bitmap,
// one word per cycle, before the first input is taken.
// Depends on fba_pkg.
module frame_bitmap_allocator
  import fba_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 1024,
  parameter int unsigned WORD_BITS  = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                frame_count_we_i,
  input  logic [COUNT_W-1:0]  frame_count_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [FRAME_W-1:0]  frame_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                used_o,
  output logic [FRAME_W-1:0]  granted_frame_o
);

  localparam int unsigned NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BW = $clog2(WORD_BITS);
  localparam int unsigned CW = ($clog2(MAX_FRAMES + 1) > COUNT_W) ?
                               $clog2(MAX_FRAMES + 1) : COUNT_W;
  localparam int unsigned XW = CW + 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

  // controller states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [COUNT_W-1:0]   frame_count_q;
  logic [FUNC_W-1:0]    op_func_q;
  logic [FRAME_W-1:0]   op_frame_q;
  logic [BW-1:0]        op_bit_q;
  logic [AW-1:0]        rd_addr_q, rd_addr_d;
  logic                 rd_en;

  // bitmap memory, registered read
  logic [WORD_BITS-1:0] mem_q [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic                 used_q, used_d;
  logic [FRAME_W-1:0]   granted_q, granted_d;

  logic [CW-1:0]        eff_count;
  logic [XW-1:0]        word_base;
  logic [XW-1:0]        word_rem;
  logic [XW-1:0]        alloc_frame;
  logic [WORD_BITS-1:0] valid_mask;
  logic [WORD_BITS-1:0] avail;
  logic [BW-1:0]        ff_idx;
  logic                 ff_hit;
  logic                 scan_last;
  logic                 frame_ok;
  logic                 cur_bit;
  logic                 out_free;
  logic                 fire;

  // count saturates at the bitmap size
  assign eff_count = (CW'(frame_count_q) > CW'(MAX_FRAMES)) ?
                     CW'(MAX_FRAMES) : CW'(frame_count_q);

  // frames covered by the word now in rdata_q
  assign word_base = XW'(rd_addr_q) * XW'(WORD_BITS);
  assign word_rem  = XW'(eff_count) - word_base;
  assign scan_last = (word_base + XW'(WORD_BITS)) >= XW'(eff_count);

  always_comb begin
    if (word_base >= XW'(eff_count)) begin
      valid_mask = '0;
    end else if (word_rem >= XW'(WORD_BITS)) begin
      valid_mask = '1;
    end else begin
      valid_mask = (WORD_BITS'(1) << word_rem[BW-1:0]) - WORD_BITS'(1);
    end
  end

  assign avail = ~rdata_q & valid_mask;

  // lowest free frame in the word
  always_comb begin
    ff_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        ff_idx = BW'(i);
      end
    end
  end

  assign ff_hit      = |avail;
  assign alloc_frame = word_base + XW'(ff_idx);
  assign frame_ok    = XW'(op_frame_q) < XW'(eff_count);
  assign cur_bit     = rdata_q[op_bit_q];
  assign out_free    = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == ST_IDLE);

  // controller: issue reads, finish an op once the result slot is free
  always_comb begin
    state_d     = state_q;
    rd_en       = 1'b0;
    rd_addr_d   = rd_addr_q;
    wr_en       = 1'b0;
    wr_addr     = rd_addr_q;
    wr_data     = rdata_q;
    fire        = 1'b0;
    status_d    = STAT_OK;
    used_d      = 1'b0;
    granted_d   = '0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (rd_addr_q == LAST_WORD) begin
          rd_addr_d = '0;
          state_d   = ST_IDLE;
        end else begin
          rd_addr_d = rd_addr_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          rd_en   = 1'b1;
          state_d = ST_BUSY;
          if (func_i == FUNC_ALLOC) begin
            rd_addr_d = '0;
          end else begin
            rd_addr_d = AW'(frame_i / WORD_BITS);
          end
        end
      end
      ST_BUSY: begin
        unique case (op_func_q)
          FUNC_ALLOC: begin
            if (ff_hit) begin
              status_d  = STAT_OK;
              granted_d = alloc_frame[FRAME_W-1:0];
              wr_data   = rdata_q | (WORD_BITS'(1) << ff_idx);
              fire      = out_free;
              wr_en     = out_free;
            end else if (scan_last) begin
              status_d = STAT_FULL;
              fire     = out_free;
            end else begin
              // next word
              rd_en     = 1'b1;
              rd_addr_d = rd_addr_q + AW'(1);
            end
          end
          FUNC_MARK: begin
            fire = out_free;
            if (!frame_ok) begin
              status_d = STAT_RANGE;
            end else if (cur_bit) begin
              status_d = STAT_USED;
            end else begin
              wr_data = rdata_q | (WORD_BITS'(1) << op_bit_q);
              wr_en   = out_free;
            end
          end
          FUNC_FREE: begin
            fire = out_free;
            if (!frame_ok) begin
              status_d = STAT_RANGE;
            end else begin
              wr_data = rdata_q & ~(WORD_BITS'(1) << op_bit_q);
              wr_en   = out_free;
            end
          end
          FUNC_QUERY: begin
            fire = out_free;
            if (!frame_ok) begin
              status_d = STAT_RANGE;
            end else begin
              used_d = cur_bit;
            end
          end
          default: begin
            fire = out_free;
          end
        endcase
        if (fire) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      rd_addr_q     <= '0;
      frame_count_q <= COUNT_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_addr_q   <= rd_addr_d;
      out_valid_q <= out_valid_d;
      if (frame_count_we_i) begin
        frame_count_q <= frame_count_i;
      end
    end
  end

  // operand and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_func_q  <= func_i;
      op_frame_q <= frame_i;
      op_bit_q   <= BW'(frame_i % WORD_BITS);
    end
    if (fire) begin
      status_q  <= status_d;
      used_q    <= used_d;
      granted_q <= granted_d;
    end
  end

  // bitmap memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr_d];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign used_o          = used_q;
  assign granted_frame_o = granted_q;

  // no memory write while waiting for a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q != ST_IDLE))
    else $error("bitmap written while idle");

  // a result is only loaded into a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending result");

  // a granted frame lies below the effective count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (op_func_q == FUNC_ALLOC) && ff_hit) |-> (alloc_frame < XW'(eff_count)))
    else $error("allocate granted a frame out of range");

  // clearing pass runs to the last word before taking requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CLEAR) && (rd_addr_q != LAST_WORD)) |=> (state_q == ST_CLEAR))
    else $error("clearing pass cut short");

endmodule

@@ test/frame_bitmap_allocator_tb.sv @@
`timescale 1ns / 100ps
// frame_bitmap_allocator_tb: self-checking bench for the frame bitmap allocator.
// A directed table runs, then random phases over several frame counts; all but pinned
// rows checked against a bitmap predictor. Depends on fba_pkg and frame_bitmap_allocator.
module frame_bitmap_allocator_tb;
  import fba_pkg::*;

  localparam int unsigned NFRAMES     = 1024;
  localparam int unsigned SETTLE      = 20;    // covers the longest allocate scan
  localparam int unsigned IDLE_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int unsigned LONG_HOLD   = 300;   // sink back-pressure stretch
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 66;

  typedef struct packed {
    status_e            status;
    logic               used;
    logic [FRAME_W-1:0] granted;
  } alloc_result_t;

  // One row of the directed table: either a frame_count write or a request.
  // Rows with pinned set carry a hand-written expected result.
  typedef struct packed {
    logic               is_cfg;
    logic [COUNT_W-1:0] count;
    func_e              op;
    logic [FRAME_W-1:0] frame;
    logic               pinned;
    alloc_result_t      want;
  } stim_row_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                frame_count_we_i = 1'b0;
  logic [COUNT_W-1:0]  frame_count_i    = COUNT_RESET;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic [FUNC_W-1:0]   func_i           = FUNC_QUERY;
  logic [FRAME_W-1:0]  frame_i          = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic                used_o;
  logic [FRAME_W-1:0]  granted_frame_o;

  // Predictor state: one bit per frame plus a shadow of the frame_count register.
  logic [NFRAMES-1:0]  frame_used   = '0;
  logic [COUNT_W-1:0]  count_shadow = COUNT_RESET;

  alloc_result_t       pending_results[$];
  int unsigned         mismatch_count = 0;
  int unsigned         idle_cycles    = 0;

  // Travels with the request payload so the checker knows whether the
  // accepted transaction has a hand-written expectation.
  logic                row_pinned = 1'b0;
  alloc_result_t       row_want   = '0;

  bit                  no_gaps     = 1'b0;  // both sides run back to back
  bit                  rx_hold_req = 1'b0;  // asks the sink for one long stall

  frame_bitmap_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frame_count_we_i(frame_count_we_i),
    .frame_count_i   (frame_count_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .frame_i         (frame_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .used_o          (used_o),
    .granted_frame_o (granted_frame_o)
  );

  always #5 clk_i = ~clk_i;

  // Bitmap predictor: applies one request to the shadow bitmap and returns
  // the result the block should give for it.
  function automatic alloc_result_t apply_request(input func_e op,
                                                  input logic [FRAME_W-1:0] fr);
    alloc_result_t r;
    int unsigned   lim;
    bit            found;
    r.status  = STAT_OK;
    r.used    = 1'b0;
    r.granted = '0;
    found     = 1'b0;
    // counts above the bitmap size saturate
    lim = (count_shadow > NFRAMES) ? NFRAMES : count_shadow;
    if (op == FUNC_ALLOC) begin
      // first fit: lowest free frame below the count
      r.status = STAT_FULL;
      for (int f = 0; f < lim && !found; f++) begin
        if (!frame_used[f]) begin
          frame_used[f] = 1'b1;
          r.status      = STAT_OK;
          r.granted     = FRAME_W'(f);
          found         = 1'b1;
        end
      end
    end else if (fr >= lim) begin
      r.status = STAT_RANGE;
    end else begin
      case (op)
        FUNC_MARK: begin
          if (frame_used[fr]) r.status = STAT_USED;
          else frame_used[fr] = 1'b1;
        end
        FUNC_FREE: begin
          frame_used[fr] = 1'b0;  // always clears, freeing a free frame is fine
        end
        default: begin
          r.used = frame_used[fr];
        end
      endcase
    end
    return r;
  endfunction

  function automatic alloc_result_t outcome(input status_e s, input logic u,
                                            input logic [FRAME_W-1:0] g);
    alloc_result_t r;
    r.status  = s;
    r.used    = u;
    r.granted = g;
    return r;
  endfunction

  function automatic stim_row_t row_req(input func_e op, input logic [FRAME_W-1:0] fr,
                                        input logic pinned, input alloc_result_t want);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.count  = '0;
    row.op     = op;
    row.frame  = fr;
    row.pinned = pinned;
    row.want   = want;
    return row;
  endfunction

  function automatic stim_row_t row_cfg(input logic [COUNT_W-1:0] value);
    stim_row_t row;
    row        = row_req(FUNC_QUERY, '0, 1'b0, outcome(STAT_OK, 1'b0, '0));
    row.is_cfg = 1'b1;
    row.count  = value;
    return row;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Present one request; returns at the edge where the transaction is accepted.
  // Valid stays high on return so a back-to-back request needs no toggle.
  task automatic offer(input func_e op, input logic [FRAME_W-1:0] fr,
                       input logic pinned, input alloc_result_t want);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op;
    frame_i    <= fr;
    row_pinned <= pinned;
    row_want   <= want;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  // Stop sending, wait for every expected result, then let a full scan's
  // worth of cycles pass so the block is surely idle.
  task automatic quiesce_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    frame_count_we_i <= 1'b1;
    frame_count_i    <= value;
    @(posedge clk_i);
    count_shadow      = value;
    frame_count_we_i <= 1'b0;
  endtask

  // Checker: results are popped before new expectations are pushed, so a
  // stray result can never match a transaction accepted in the same cycle.
  always @(posedge clk_i) begin : result_check
    alloc_result_t model;
    alloc_result_t want;
    if (rst_ni) begin
      if ((out_valid_o & out_ready_i) === 1'b1) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result with no pending request");
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.status)
            note_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
          if (used_o !== want.used)
            note_mismatch($sformatf("used got %0d want %0d", used_o, want.used));
          if (granted_frame_o !== want.granted)
            note_mismatch($sformatf("granted_frame got %0d want %0d",
                                    granted_frame_o, want.granted));
        end
      end
      if ((in_valid_i & in_ready_o) === 1'b1) begin
        model = apply_request(func_e'(func_i), frame_i);
        pending_results.push_back(row_pinned ? row_want : model);
      end
    end
  end

  // Watchdog: ends the run if no transaction moves for too long.
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i & in_ready_o) === 1'b1 || (out_valid_o & out_ready_i) === 1'b1)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL frame_bitmap_allocator");
      $finish;
    end
  end

  // Result sink: random stall per result, one long hold when asked.
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        stall       = LONG_HOLD;
        rx_hold_req = 1'b0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 19);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  initial begin : stimulus
    stim_row_t          directed[$];
    logic [COUNT_W-1:0] phase_count [PHASES];
    func_e              op;
    logic [FRAME_W-1:0] fr;
    int unsigned        lim;
    int unsigned        pick;
    int unsigned        mid;

    // Directed table, starting from the reset count of 1024 and an empty bitmap.
    directed.push_back(row_req(FUNC_QUERY, 10'd0,    1'b1, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_ALLOC, 10'd1023, 1'b1, outcome(STAT_OK,    1'b0, 10'd0)));
    // marking a frame already taken
    directed.push_back(row_req(FUNC_MARK,  10'd0,    1'b1, outcome(STAT_USED,  1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_QUERY, 10'd0,    1'b1, outcome(STAT_OK,    1'b1, 10'd0)));
    directed.push_back(row_req(FUNC_MARK,  10'd1023, 1'b1, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_QUERY, 10'd1023, 1'b1, outcome(STAT_OK,    1'b1, 10'd0)));
    directed.push_back(row_req(FUNC_FREE,  10'd1023, 1'b1, outcome(STAT_OK,    1'b0, 10'd0)));
    // freeing a free frame must clear, not toggle
    directed.push_back(row_req(FUNC_FREE,  10'd1023, 1'b1, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_QUERY, 10'd1023, 1'b1, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_MARK,  10'd1,    1'b1, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_ALLOC, 10'd0,    1'b1, outcome(STAT_OK,    1'b0, 10'd2)));
    directed.push_back(row_req(FUNC_MARK,  10'd64,   1'b1, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_FREE,  10'd0,    1'b0, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_ALLOC, 10'd512,  1'b0, outcome(STAT_OK,    1'b0, 10'd0)));
    // small count: out-of-range frames, then run out of frames
    directed.push_back(row_cfg(11'd5));
    directed.push_back(row_req(FUNC_MARK,  10'd5,    1'b1, outcome(STAT_RANGE, 1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_QUERY, 10'd1023, 1'b1, outcome(STAT_RANGE, 1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_FREE,  10'd5,    1'b1, outcome(STAT_RANGE, 1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_ALLOC, 10'd0,    1'b0, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_ALLOC, 10'd0,    1'b0, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_ALLOC, 10'd0,    1'b1, outcome(STAT_FULL,  1'b0, 10'd0)));
    // zero count: nothing in range, allocate always full
    directed.push_back(row_cfg(11'd0));
    directed.push_back(row_req(FUNC_ALLOC, 10'd0,    1'b1, outcome(STAT_FULL,  1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_QUERY, 10'd0,    1'b1, outcome(STAT_RANGE, 1'b0, 10'd0)));
    // count above the bitmap size saturates to 1024
    directed.push_back(row_cfg(11'd2047));
    directed.push_back(row_req(FUNC_QUERY, 10'd1023, 1'b1, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_MARK,  10'd1023, 1'b1, outcome(STAT_OK,    1'b0, 10'd0)));
    directed.push_back(row_req(FUNC_FREE,  10'd512,  1'b0, outcome(STAT_OK,    1'b0, 10'd0)));

    phase_count = '{11'd1024, 11'd130, 11'd2047, 11'd0, 11'd1, 11'd1023, 11'd64, 11'd0};
    phase_count[PHASES-1] = COUNT_W'($urandom_range(0, 2047));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        quiesce_block();
        write_count(directed[i].count);
      end else begin
        offer(directed[i].op, directed[i].frame, directed[i].pinned, directed[i].want);
      end
    end

    // Random phases. Allocates dominate so the bitmap fills from the bottom
    // and later scans walk several words; most frames fall below the count.
    for (int p = 0; p < PHASES; p++) begin
      quiesce_block();
      write_count(phase_count[p]);
      no_gaps = (p % 3 == 2);
      if (p == 1) rx_hold_req = 1'b1;  // sink stalls long while requests keep coming
      mid = $urandom_range(10, PHASE_ITEMS - 10);
      lim = (phase_count[p] > NFRAMES) ? NFRAMES : phase_count[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == mid) quiesce_block();  // sender pauses until all results are in
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = FUNC_ALLOC;
        else if (pick < 65) op = FUNC_MARK;
        else if (pick < 82) op = FUNC_QUERY;
        else                op = FUNC_FREE;
        if (lim != 0 && $urandom_range(0, 3) != 0)
          fr = FRAME_W'($urandom_range(0, lim - 1));
        else
          fr = FRAME_W'($urandom_range(0, NFRAMES - 1));
        offer(op, fr, 1'b0, outcome(STAT_OK, 1'b0, '0));
      end
    end

    no_gaps = 1'b0;
    quiesce_block();
    if (mismatch_count == 0)
      $display("PASS frame_bitmap_allocator");
    else
      $display("FAIL frame_bitmap_allocator");
    $finish;
  end

endmodule
